// ----- hw/rtl/ralu_pkg.sv -----
// Package for the rational ALU: operation codes, payload structs, widths, back-end states.
// No dependencies.
package ralu_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ResNumWidth  = 33;
  localparam int unsigned ResDenWidth  = 32;
  localparam int unsigned OpWidth      = 3;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [OpWidth-1:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpEq  = 3'd4,
    OpNe  = 3'd5,
    OpRsv6 = 3'd6,
    OpRsv7 = 3'd7
  } op_e;

  typedef struct packed {
    logic [OpWidth-1:0]             op;
    logic signed [OperandWidth-1:0] a_num;
    logic signed [OperandWidth-1:0] a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic signed [OperandWidth-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [ResNumWidth-1:0] res_num;
    logic [ResDenWidth-1:0]        res_den;
    logic                          compare_true;
    logic                          error;
  } out_item_t;

  typedef enum logic [2:0] {
    BkIdle, BkMul, BkSum, BkGcd, BkDivN, BkDivD, BkOut
  } bk_state_e;

endpackage

// ----- hw/rtl/ralu_front.sv -----
// Front end: accepts items and queues them for the back end.
// Depends on ralu_pkg.
module ralu_front import ralu_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t in_item_i,
  input  logic     push,
  output logic     full,
  output in_item_t q_item_o,
  output logic     q_valid_o,
  input  logic     q_take_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;
  logic                do_push, do_pop;

  assign full      = (cnt_q == (PtrW+1)'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign do_push   = push && !full;
  assign do_pop    = q_take_i && q_valid_o;
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end
endmodule

// ----- hw/rtl/ralu_divu.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ralu_pkg.
module ralu_divu import ralu_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W+1);
  logic [W-1:0]    q_q, r_q, d_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [W:0]      trial;

  assign trial  = {r_q, q_q[W-1]} - {1'b0, d_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = q_q;
  assign rem_o  = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= CntW'(W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i; r_q <= '0; d_q <= divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      if (!trial[W]) begin
        r_q <= trial[W-1:0];
        q_q <= {q_q[W-2:0], 1'b1};
      end else begin
        r_q <= {r_q[W-2:0], q_q[W-1]};
        q_q <= {q_q[W-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- hw/rtl/ralu_back.sv -----
// Back end: cross-multiply, Euclid GCD and reduction on a shared divider.
// Depends on ralu_pkg and ralu_divu.
module ralu_back import ralu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  q_item_i,
  input  logic      q_valid_i,
  output logic      q_take_o,
  output out_item_t res_o,
  output logic      empty,
  input  logic      pop
);
  localparam int unsigned OpW = OperandWidth;
  localparam int unsigned PW = 2*OpW;
  localparam int unsigned SW = PW+1;
  localparam int unsigned MW = SW;

  bk_state_e state_q, state_d;
  in_item_t  it_q;
  logic signed [PW-1:0] p0_q, p1_q, pd_q;
  logic [MW-1:0] nmag_q, dmag_q, gx_q, gy_q, rn_q;
  logic neg_q;
  out_item_t acc_q;
  out_item_t res_q;
  logic      full_q;
  // tracks whether a division of this state is in flight
  logic      u_busy_q;

  logic          dv_start, dv_done;
  logic [MW-1:0] dv_a, dv_b, dv_quot, dv_rem;
  logic signed [OpW-1:0] m0a, m0b, m1a, m1b, mda, mdb;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] den_ext;

  ralu_divu #(.W(MW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(dv_a), .divisor_i(dv_b),
    .done_o(dv_done), .quot_o(dv_quot), .rem_o(dv_rem)
  );

  always_comb begin
    m0a = it_q.a_num; m0b = it_q.b_den;
    m1a = it_q.b_num; m1b = it_q.a_den;
    mda = it_q.a_den; mdb = it_q.b_den;
    unique case (op_e'(it_q.op))
      OpMul: m0b = it_q.b_num;
      OpDiv: mdb = it_q.b_num;
      default: ;
    endcase
  end

  assign den_ext = SW'(pd_q);
  always_comb begin
    unique case (op_e'(it_q.op))
      OpAdd:   sum = SW'(p0_q) + SW'(p1_q);
      OpSub:   sum = SW'(p0_q) - SW'(p1_q);
      default: sum = SW'(p0_q);
    endcase
  end

  assign q_take_o = (state_q == BkIdle) && q_valid_i;
  assign empty    = !full_q;
  assign res_o    = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (q_valid_i) state_d = BkMul;
      BkMul:  state_d = (it_q.op inside {OpEq, OpNe, OpRsv6, OpRsv7}) ? BkOut : BkSum;
      BkSum:  state_d = (pd_q == '0 || sum == '0) ? BkOut : BkGcd;
      BkGcd:  if (gy_q == '0) state_d = BkDivN;
      BkDivN: if (dv_done) state_d = BkDivD;
      BkDivD: if (dv_done) state_d = BkOut;
      BkOut:  if (!full_q) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    dv_start = 1'b0; dv_a = gx_q; dv_b = gy_q;
    unique case (state_q)
      BkGcd: dv_start = (gy_q != '0) && !u_busy_q;
      BkDivN: begin dv_a = nmag_q; dv_b = gx_q; dv_start = !u_busy_q; end
      BkDivD: begin dv_a = dmag_q; dv_b = gx_q; dv_start = !u_busy_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle; u_busy_q <= 1'b0; full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (dv_done) u_busy_q <= 1'b0;
      else if (dv_start) u_busy_q <= 1'b1;
      if (state_q == BkOut && !full_q) full_q <= 1'b1;
      else if (pop && full_q) full_q <= 1'b0;
    end
  end

  // finished result moves to the output register once it is free
  always_ff @(posedge clk_i) begin
    if (state_q == BkOut && !full_q) res_q <= acc_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i) it_q <= q_item_i;
        acc_q <= '0;
      end
      BkMul: begin
        p0_q <= PW'(m0a * m0b);
        p1_q <= PW'(m1a * m1b);
        pd_q <= PW'(mda * mdb);
        if (op_e'(it_q.op) == OpEq)
          acc_q.compare_true <= (it_q.a_num == it_q.b_num) && (it_q.a_den == it_q.b_den);
        if (op_e'(it_q.op) == OpNe)
          acc_q.compare_true <= (it_q.a_num != it_q.b_num) || (it_q.a_den != it_q.b_den);
      end
      BkSum: begin
        neg_q  <= sum[SW-1] ^ den_ext[SW-1];
        nmag_q <= sum[SW-1] ? MW'(-sum) : MW'(sum);
        dmag_q <= den_ext[SW-1] ? MW'(-den_ext) : MW'(den_ext);
        gx_q   <= sum[SW-1] ? MW'(-sum) : MW'(sum);
        gy_q   <= den_ext[SW-1] ? MW'(-den_ext) : MW'(den_ext);
        if (pd_q == '0) acc_q.error <= 1'b1;
        else if (sum == '0) acc_q.res_den <= ResDenWidth'(1);
      end
      BkGcd: if (dv_done) begin gx_q <= gy_q; gy_q <= dv_rem; end
      BkDivN: if (dv_done) rn_q <= neg_q ? MW'(-dv_quot) : dv_quot;
      BkDivD: if (dv_done) begin
        acc_q.res_num <= ResNumWidth'(signed'(rn_q));
        acc_q.res_den <= ResDenWidth'(dv_quot);
      end
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/rational_alu_with_reduction.sv -----
// Top level of the rational ALU; instantiates ralu_front and ralu_back.
// Depends on ralu_pkg, ralu_front and ralu_back.
//
// Signed fraction ALU with queue handshakes on both sides. Compares and unused op
// codes skip the sum; zero results and zero denominators skip the reduction;
// other results are reduced by Euclid steps followed by two divisions. All
// divisions run on one radix-2 divider of 2W+1 bits, where W is the operand
// width (16). A two-entry queue lets new items be taken while one is
// reduced, and a finished result waits in its own register.
module rational_alu_with_reduction import ralu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      push,
  output logic      full,
  output out_item_t out_item_o,
  output logic      empty,
  input  logic      pop
);
  in_item_t q_item;
  logic     q_valid, q_take;

  ralu_front #(.Depth(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_item_i, .push, .full,
    .q_item_o(q_item), .q_valid_o(q_valid), .q_take_i(q_take)
  );

  ralu_back u_back (
    .clk_i, .rst_ni, .q_item_i(q_item), .q_valid_i(q_valid), .q_take_o(q_take),
    .res_o(out_item_o), .empty, .pop
  );
endmodule

// ----- hw/rtl/ralu_checker.sv -----
// Port-level checker for rational_alu_with_reduction, bound to the top.
// Depends on ralu_pkg.
module ralu_checker import ralu_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.error |-> out_item_o.res_den == '0 && !out_item_o.compare_true)
    else $error("error result with nonzero fields");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.res_num != '0 |-> out_item_o.res_den != '0)
    else $error("nonzero numerator over zero denominator");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while waiting");
endmodule

bind rational_alu_with_reduction ralu_checker u_chk (.*);
